// File: hdl/float32_add_sub_truncating_assert.svh
// Assertion macros used by the port checker of the single-precision adder.
// Depends on nothing; include by bare file name.
`ifndef FLOAT32_ADD_SUB_TRUNCATING_ASSERT_SVH
`define FLOAT32_ADD_SUB_TRUNCATING_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define FAS_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("fas port assertion failed");

// Next-cycle implication, masked while reset is high.
`define FAS_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fas port assertion failed");

`endif

// File: hdl/fas_pkg.sv
// Shared constants and types for the single-precision add/subtract pipeline.
// No dependencies.
package fas_pkg;

  localparam int SIGN_POS   = 31;
  localparam int EXP_POS    = 23;
  localparam int EXP_TOP    = 30;
  localparam int EXP_W      = EXP_TOP - EXP_POS + 1;
  localparam int FRAC_W     = EXP_POS;
  localparam int MANT_W     = FRAC_W + 1;
  localparam int LZC_W      = $clog2(MANT_W + 1);
  localparam int NORM_EXP_W = EXP_W + 2;
  localparam int ALIGN_W    = $clog2(MANT_W);

  typedef logic [SIGN_POS:0]   fp_word_t;
  typedef logic [EXP_W-1:0]    fp_exp_t;
  typedef logic [MANT_W-1:0]   fp_mant_t;
  typedef logic [LZC_W-1:0]    lz_count_t;

endpackage

// File: hdl/fas_lzc.sv
// Leading-zero counter over the 24-bit mantissa used by the normaliser.
// Depends on fas_pkg. An all-zero input gives MANT_W.
module fas_lzc (
  input  fas_pkg::fp_mant_t value,
  output fas_pkg::lz_count_t count
);

  always_comb begin
    count = fas_pkg::lz_count_t'(fas_pkg::MANT_W);
    // lowest set bit first, so the highest one wins
    for (int i = 0; i < fas_pkg::MANT_W; i++) begin
      if (value[i]) begin
        count = fas_pkg::lz_count_t'(fas_pkg::MANT_W - 1 - i);
      end
    end
  end

endmodule

// File: hdl/float32_add_sub_truncating.sv
// Single-precision add/subtract, truncating, no rounding, four register stages.
// The result word is registered in stage 1, stage 2, stage 3 and the output register in turn.
// Throughput: one word per cycle; a stall holds the occupied stages, bubbles close up.
// Stages: compare/swap, align/add, leading-zero count, normalise/pack.
// Reset (synchronous, rst high) empties all stages; payload registers keep data.
module float32_add_sub_truncating (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  fas_pkg::fp_word_t  operand_a,
  input  fas_pkg::fp_word_t  operand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output fas_pkg::fp_word_t  sum_bits,
  output logic               range_error
);

  localparam fas_pkg::fp_word_t SIGN_BIT = fas_pkg::fp_word_t'(1) << fas_pkg::SIGN_POS;

  // ready chain
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1 registers
  logic              s1_valid;
  logic              s1_bypass;
  fas_pkg::fp_word_t s1_bypass_val;
  logic              s1_sign;
  logic              s1_sub;
  fas_pkg::fp_exp_t  s1_exp;
  fas_pkg::fp_mant_t s1_vb;
  fas_pkg::fp_mant_t s1_vs;
  fas_pkg::fp_exp_t  s1_dist;

  // stage 2 registers
  logic                s2_valid;
  logic                s2_bypass;
  fas_pkg::fp_word_t   s2_bypass_val;
  logic                s2_sign;
  fas_pkg::fp_exp_t    s2_exp;
  logic [fas_pkg::MANT_W:0] s2_sum;

  // stage 3 registers
  logic                s3_valid;
  logic                s3_bypass;
  fas_pkg::fp_word_t   s3_bypass_val;
  logic                s3_sign;
  logic                s3_zero;
  logic [fas_pkg::MANT_W:0] s3_sum;
  fas_pkg::lz_count_t  s3_lz;
  logic [fas_pkg::NORM_EXP_W-1:0] s3_exp;

  // stage 1 logic
  fas_pkg::fp_word_t b_eff, big, lesser;
  logic              cancel, swap;
  fas_pkg::fp_exp_t  big_exp, lesser_exp;

  // stage 2 logic
  fas_pkg::fp_mant_t        vs_aligned;
  logic [fas_pkg::MANT_W:0] sum_next;

  // stage 3 logic
  fas_pkg::lz_count_t             lz;
  logic [fas_pkg::NORM_EXP_W-1:0] exp_next;

  // stage 4 logic
  fas_pkg::fp_mant_t             shifted;
  logic [fas_pkg::FRAC_W-1:0]    frac_next;
  fas_pkg::fp_word_t             sum_bits_next;
  logic                          range_next;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_ready = rdy1;

  // ---- stage 1: negate, compare magnitudes, swap, pick out zero cases
  always_comb begin
    b_eff = operand_b;
    if (mode) begin
      b_eff = (operand_b[fas_pkg::EXP_TOP:0] == '0) ? '0 : (operand_b ^ SIGN_BIT);
    end
    cancel = (operand_a[fas_pkg::EXP_TOP:0] == b_eff[fas_pkg::EXP_TOP:0]) &&
             (operand_a[fas_pkg::SIGN_POS] != b_eff[fas_pkg::SIGN_POS]);
    swap   = b_eff[fas_pkg::EXP_TOP:0] > operand_a[fas_pkg::EXP_TOP:0];
    big    = swap ? b_eff : operand_a;
    lesser = swap ? operand_a : b_eff;
    big_exp    = big[fas_pkg::EXP_TOP:fas_pkg::EXP_POS];
    lesser_exp = lesser[fas_pkg::EXP_TOP:fas_pkg::EXP_POS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_bypass     <= cancel || (lesser[fas_pkg::EXP_TOP:0] == '0);
      if (cancel) begin
        s1_bypass_val <= '0;
      end else if (big[fas_pkg::EXP_TOP:0] == '0) begin
        s1_bypass_val <= lesser;
      end else begin
        s1_bypass_val <= big;
      end
      s1_sign <= big[fas_pkg::SIGN_POS];
      s1_sub  <= big[fas_pkg::SIGN_POS] != lesser[fas_pkg::SIGN_POS];
      s1_exp  <= big_exp;
      s1_dist <= big_exp - lesser_exp;
      s1_vb   <= {1'b1, big[fas_pkg::FRAC_W-1:0]};
      s1_vs   <= {1'b1, lesser[fas_pkg::FRAC_W-1:0]};
    end
  end

  // ---- stage 2: align the smaller mantissa, add or subtract
  always_comb begin
    if (s1_dist >= fas_pkg::fp_exp_t'(fas_pkg::MANT_W)) begin
      vs_aligned = '0;
    end else begin
      vs_aligned = s1_vs >> s1_dist[fas_pkg::ALIGN_W-1:0];
    end
    if (s1_sub) begin
      sum_next = {1'b0, s1_vb} - {1'b0, vs_aligned};
    end else begin
      sum_next = {1'b0, s1_vb} + {1'b0, vs_aligned};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_bypass     <= s1_bypass;
      s2_bypass_val <= s1_bypass_val;
      s2_sign       <= s1_sign;
      s2_exp        <= s1_exp;
      s2_sum        <= sum_next;
    end
  end

  // ---- stage 3: count leading zeros, adjust exponent
  fas_lzc u_lzc (
    .value (s2_sum[fas_pkg::MANT_W-1:0]),
    .count (lz)
  );

  always_comb begin
    if (s2_sum[fas_pkg::MANT_W]) begin
      exp_next = {2'b00, s2_exp} + fas_pkg::NORM_EXP_W'(1);
    end else begin
      exp_next = {2'b00, s2_exp} - fas_pkg::NORM_EXP_W'(lz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (rdy3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_bypass     <= s2_bypass;
      s3_bypass_val <= s2_bypass_val;
      s3_sign       <= s2_sign;
      s3_zero       <= s2_sum == '0;
      s3_sum        <= s2_sum;
      s3_lz         <= s2_sum[fas_pkg::MANT_W] ? '0 : lz;
      s3_exp        <= exp_next;
    end
  end

  // ---- stage 4: normalise shift, range check, pack
  always_comb begin
    shifted = s3_sum[fas_pkg::MANT_W-1:0] << s3_lz;
    if (s3_sum[fas_pkg::MANT_W]) begin
      frac_next = s3_sum[fas_pkg::MANT_W-1:1];
    end else begin
      frac_next = shifted[fas_pkg::FRAC_W-1:0];
    end
    sum_bits_next = '0;
    range_next    = 1'b0;
    if (s3_bypass) begin
      sum_bits_next = s3_bypass_val;
    end else if (s3_zero) begin
      sum_bits_next = '0;
    end else if (s3_exp[fas_pkg::NORM_EXP_W-1] || s3_exp[fas_pkg::EXP_W]) begin
      // exponent went below zero or above the field
      range_next = 1'b1;
    end else begin
      sum_bits_next = {s3_sign, s3_exp[fas_pkg::EXP_W-1:0], frac_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      sum_bits    <= sum_bits_next;
      range_error <= range_next;
    end
  end

endmodule

// File: hdl/fas_port_checker.sv
// Port-level checks for the single-precision add/subtract pipeline, bound to the top.
// Depends on fas_pkg and float32_add_sub_truncating_assert.svh.
`include "float32_add_sub_truncating_assert.svh"

module fas_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input fas_pkg::fp_word_t sum_bits,
  input logic              range_error
);

  // a flagged result carries a zero pattern
  `FAS_ASSERT_IMP(a_range_zero, clk, rst, out_valid && range_error, sum_bits == '0)
  // a taken output frees every stage, so input is never back-pressured then
  `FAS_ASSERT_IMP(a_ready_follows, clk, rst, out_ready, in_ready)
  `FAS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `FAS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(sum_bits))

endmodule

bind float32_add_sub_truncating fas_port_checker u_fas_port_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .sum_bits    (sum_bits),
  .range_error (range_error)
);
